### design/ncdf_pkg.sv
// Shared types, constants and the delimiter match function of the message deframer.
package ncdf_pkg;

    localparam int SIZE_BITS   = 32;
    localparam int TAG_LEN     = 6;
    localparam int MAX_RESULTS = 6;

    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_BRACKET = 8'h5D;
    localparam logic [7:0] CH_GT      = 8'h3E;

    localparam logic [7:0] END_TAG [TAG_LEN] = '{
        CH_BRACKET, CH_BRACKET, CH_GT, CH_BRACKET, CH_BRACKET, CH_GT
    };

    localparam logic REG_FRAMING_MODE = 1'b0;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ZERO_SIZE = 2'd1,
        ERR_NO_CHUNK  = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       message_end;
        t_err       error_code;
    } t_result;

    // Longest delimiter prefix that is a suffix of the held prefix followed by the new byte.
    function automatic logic [2:0] tag_fallback(input logic [2:0] held, input logic [7:0] b);
        logic [2:0] k;
        k = 3'd0;
        case (held)
            3'd0: k = (b == CH_BRACKET) ? 3'd1 : 3'd0;
            3'd1: k = (b == CH_BRACKET) ? 3'd2 : 3'd0;
            3'd2: begin
                if (b == CH_GT) begin
                    k = 3'd3;
                end else if (b == CH_BRACKET) begin
                    k = 3'd2;
                end
            end
            3'd3: k = (b == CH_BRACKET) ? 3'd4 : 3'd0;
            3'd4: k = (b == CH_BRACKET) ? 3'd5 : 3'd0;
            3'd5: begin
                if (b == CH_GT) begin
                    k = 3'd6;
                end else if (b == CH_BRACKET) begin
                    k = 3'd2;
                end
            end
            default: k = 3'd0;
        endcase
        return k;
    endfunction

endpackage

### design/ncdf_result_queue.sv
// Result buffer for all results of one byte; hands one out per cycle unless stalled.
module ncdf_result_queue (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_load,
    input  logic [2:0]                                        i_num,
    input  ncdf_pkg::t_result [ncdf_pkg::MAX_RESULTS-1:0]     i_items,
    output logic                                              o_free,
    output logic                                              o_out_valid,
    input  logic                                              i_out_stall,
    output ncdf_pkg::t_result                                 o_item,
    output logic                                              o_last
);
    import ncdf_pkg::*;

    t_result [MAX_RESULTS-1:0] r_items;
    logic [2:0]                r_num;
    logic [2:0]                r_pos;
    logic                      fire;

    assign o_out_valid = (r_num != 3'd0);
    assign o_item      = r_items[r_pos];
    assign o_last      = (r_pos == r_num - 3'd1);
    assign fire        = o_out_valid && !i_out_stall;
    assign o_free      = !o_out_valid || (fire && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 3'd0;
            r_pos <= 3'd0;
        end else if (i_load) begin
            r_num <= i_num;
            r_pos <= 3'd0;
        end else if (fire) begin
            if (o_last) begin
                r_num <= 3'd0;
                r_pos <= 3'd0;
            end else begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_items;
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_num != 3'd0) |-> (r_pos < r_num))
        else $error("result position beyond stored count");

    a_num_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num <= 3'(MAX_RESULTS))
        else $error("result count above maximum");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("results loaded over undelivered results");

endmodule

### design/netconf_message_deframer.sv
// Top level of the NETCONF message deframer: byte input, framing state and config port.
//
// Received bytes enter on i_in_valid/i_rx_byte and are taken at an edge where o_in_stall
// is low. Results leave on o_out_valid with o_data_byte, o_data_valid, o_message_end,
// o_error_code and o_last_result; the receiver holds them with i_out_stall.
// A byte is registered on entry, then decoded from the input register into a result
// buffer of up to six results, which it enters once the buffer is free.
// One byte per cycle is sustained while each byte gives at most one result and no stall
// comes; a byte that releases held delimiter bytes holds the buffer until its results
// drain, one per cycle unless stalled. Bytes that give no result leave the buffer free.
// While the receiver stalls, the buffer holds and the input register fills, after which
// o_in_stall rises. No item is lost or repeated.
// Reset selects end-tag framing, clears all framing state and empties both registers.
// Writing framing_mode at address 0 of the APB port clears the framing state as reset does.
module netconf_message_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_message_end,
    output logic [1:0]  o_error_code,
    output logic        o_last_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ncdf_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT_LF    = 3'd0,
        PH_HUNT_HASH  = 3'd1,
        PH_HDR_FIRST  = 3'd2,
        PH_HDR_DIGITS = 3'd3,
        PH_HDR_SKIP   = 3'd4,
        PH_HDR_END    = 3'd5,
        PH_DATA       = 3'd6,
        PH_OVF        = 3'd7
    } t_phase;

    logic                      r_mode;
    t_phase                    r_phase,     n_phase;
    logic [2:0]                r_tag_cnt,   n_tag_cnt;
    logic [SIZE_BITS-1:0]      r_size_acc,  n_size_acc;
    logic [SIZE_BITS-1:0]      r_remaining, n_remaining;
    logic                      r_chunk_seen, n_chunk_seen;
    logic                      r_in_vld;
    logic [7:0]                r_in_byte;

    logic                      cfg_write;
    logic                      q_free;
    logic                      move;
    logic [2:0]                res_num;
    t_result [MAX_RESULTS-1:0] res_items;
    t_result                   out_item;

    logic [2:0]                held;
    logic [2:0]                keep;
    logic [2:0]                ndata;
    logic                      is_digit;
    logic [SIZE_BITS+3:0]      size_next;
    logic [SIZE_BITS-1:0]      rem_dec;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_FRAMING_MODE) ? {31'd0, r_mode} : 32'd0;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FRAMING_MODE);

    assign move       = r_in_vld && q_free;
    assign o_in_stall = r_in_vld && !q_free;

    assign held      = (r_tag_cnt >= 3'(TAG_LEN)) ? 3'd0 : r_tag_cnt;
    assign keep      = tag_fallback(held, r_in_byte);
    assign ndata     = held + 3'd1 - keep;
    assign is_digit  = r_in_byte inside {[CH_ZERO:CH_NINE]};
    assign size_next = ({4'd0, r_size_acc} << 3) + ({4'd0, r_size_acc} << 1)
                     + {{SIZE_BITS{1'b0}}, r_in_byte[3:0]};
    assign rem_dec   = (r_remaining != '0) ? r_remaining - SIZE_BITS'(1) : '0;

    always_comb begin
        n_phase      = r_phase;
        n_tag_cnt    = r_tag_cnt;
        n_size_acc   = r_size_acc;
        n_remaining  = r_remaining;
        n_chunk_seen = r_chunk_seen;
        res_num      = 3'd0;
        res_items    = '0;

        if (!r_mode) begin
            if (keep == 3'(TAG_LEN)) begin
                res_items[0].message_end = 1'b1;
                res_num   = 3'd1;
                n_tag_cnt = 3'd0;
            end else begin
                for (int i = 0; i < MAX_RESULTS; i++) begin
                    if (3'(i) < ndata) begin
                        res_items[i].data_valid = 1'b1;
                        res_items[i].data_byte  = (3'(i) < held) ? END_TAG[i] : r_in_byte;
                    end
                end
                res_num   = ndata;
                n_tag_cnt = keep;
            end
        end else begin
            case (r_phase)
                PH_HUNT_LF: begin
                    if (r_in_byte == CH_LF) begin
                        n_phase = PH_HUNT_HASH;
                    end
                end
                PH_HUNT_HASH: begin
                    if (r_in_byte == CH_HASH) begin
                        n_size_acc = '0;
                        n_phase    = PH_HDR_FIRST;
                    end else if (r_in_byte != CH_LF) begin
                        n_phase = PH_HUNT_LF;
                    end
                end
                PH_HDR_FIRST, PH_HDR_DIGITS, PH_HDR_SKIP: begin
                    if (r_in_byte == CH_LF) begin
                        if (r_size_acc == '0) begin
                            res_items[0].error_code = ERR_ZERO_SIZE;
                            res_num      = 3'd1;
                            n_chunk_seen = 1'b0;
                            n_phase      = PH_HUNT_LF;
                        end else begin
                            n_remaining  = r_size_acc;
                            n_chunk_seen = 1'b1;
                            n_phase      = PH_DATA;
                        end
                        n_size_acc = '0;
                    end else if (r_phase == PH_HDR_FIRST && r_in_byte == CH_HASH) begin
                        n_phase = PH_HDR_END;
                    end else if (r_phase != PH_HDR_SKIP && is_digit) begin
                        if (size_next[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
                            n_size_acc = '0;
                            n_phase    = PH_OVF;
                        end else begin
                            n_size_acc = size_next[SIZE_BITS-1:0];
                            n_phase    = PH_HDR_DIGITS;
                        end
                    end else begin
                        n_phase = PH_HDR_SKIP;
                    end
                end
                PH_HDR_END: begin
                    if (r_in_byte == CH_LF) begin
                        if (r_chunk_seen) begin
                            res_items[0].message_end = 1'b1;
                        end else begin
                            res_items[0].error_code = ERR_NO_CHUNK;
                        end
                        res_num      = 3'd1;
                        n_chunk_seen = 1'b0;
                        n_phase      = PH_HUNT_LF;
                    end else begin
                        n_size_acc = '0;
                        n_phase    = PH_HDR_SKIP;
                    end
                end
                PH_DATA: begin
                    res_items[0].data_valid = 1'b1;
                    res_items[0].data_byte  = r_in_byte;
                    res_num     = 3'd1;
                    n_remaining = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_HUNT_LF;
                    end
                end
                default: begin
                    if (r_in_byte == CH_LF) begin
                        res_items[0].error_code = ERR_OVERFLOW;
                        res_num      = 3'd1;
                        n_chunk_seen = 1'b0;
                        n_size_acc   = '0;
                        n_phase      = PH_HUNT_LF;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_phase      <= PH_HUNT_LF;
            r_tag_cnt    <= 3'd0;
            r_size_acc   <= '0;
            r_remaining  <= '0;
            r_chunk_seen <= 1'b0;
        end else if (cfg_write) begin
            r_mode       <= pwdata[0];
            r_phase      <= PH_HUNT_LF;
            r_tag_cnt    <= 3'd0;
            r_size_acc   <= '0;
            r_remaining  <= '0;
            r_chunk_seen <= 1'b0;
        end else if (move) begin
            r_phase      <= n_phase;
            r_tag_cnt    <= n_tag_cnt;
            r_size_acc   <= n_size_acc;
            r_remaining  <= n_remaining;
            r_chunk_seen <= n_chunk_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    ncdf_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (move),
        .i_num       (res_num),
        .i_items     (res_items),
        .o_free      (q_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_item      (out_item),
        .o_last      (o_last_result)
    );

    assign o_data_byte   = out_item.data_byte;
    assign o_data_valid  = out_item.data_valid;
    assign o_message_end = out_item.message_end;
    assign o_error_code  = out_item.error_code;

    a_tag_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_cnt < 3'(TAG_LEN))
        else $error("delimiter match count reached full length without clearing");

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_remaining != '0))
        else $error("chunk data phase with no bytes remaining");

    a_chunked_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode |-> (r_tag_cnt == 3'd0))
        else $error("delimiter match held in chunked mode");

endmodule

### verif/netconf_message_deframer_tb.sv
// Self-checking testbench for the NETCONF message deframer in both framing modes.
module netconf_message_deframer_tb;
    import ncdf_pkg::*;

    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 60;
    localparam int          SEG_COUNT     = 6;
    localparam int          SEG_ITEMS     = 42;
    localparam int          PRINT_CAP     = 40;
    localparam logic [5:0]  SEG_MODES     = 6'b011010;
    localparam int          UNMAPPED_SEG  = 4;
    localparam int          PRESSURE_SEG  = 5;
    localparam logic [2:0]  MODE_ADDR     = 3'(4 * int'(REG_FRAMING_MODE));
    localparam logic [2:0]  UNMAPPED_ADDR = 3'd4;
    localparam logic [63:0] SIZE_MAX64    = (64'd1 << SIZE_BITS) - 64'd1;

    typedef enum logic [2:0] {
        HUNT_LF, HUNT_HASH, HDR_FIRST, HDR_DIGITS, HDR_SKIP, HDR_END, CHUNK_DATA, HDR_OVERFLOW
    } t_chunk_phase;

    typedef enum logic [2:0] {
        EXP_PREDICTED, EXP_SAME_BYTE, EXP_MSG_END, EXP_ZERO_SIZE, EXP_NO_CHUNK
    } t_exp_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       msg_end;
        t_err       err;
        logic       last;
    } t_deframed;

    typedef struct {
        logic       mode;
        logic [7:0] rx;
        t_exp_kind  kind;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_data_valid;
    logic        o_message_end;
    logic [1:0]  o_error_code;
    logic        o_last_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    netconf_message_deframer DUT (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state.
    logic                 framing_mode = 1'b0;
    t_chunk_phase         chunk_phase;
    logic [2:0]           tag_held;
    logic [SIZE_BITS-1:0] size_acc;
    logic [SIZE_BITS-1:0] chunk_left;
    logic                 chunk_seen;

    t_deframed   deframed_q[$];
    logic [7:0]  tx_bytes[$];
    t_dir_row    dir_rows[$];

    int          in_idle_pct = 9;
    int          out_idle_pct = 48;
    logic        hold_arm = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          bytes_in = 0;
    int          results_checked = 0;
    int          ends_seen = 0;
    int          errors_seen = 0;
    int          cycle_count = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic clear_framing();
        chunk_phase = HUNT_LF;
        tag_held = 3'd0;
        size_acc = '0;
        chunk_left = '0;
        chunk_seen = 1'b0;
    endtask

    task automatic expect_result(input logic [7:0] data, input logic valid,
                                 input logic msg_end, input t_err err);
        deframed_q.push_back('{data: data, valid: valid, msg_end: msg_end, err: err,
                               last: 1'b0});
    endtask

    task automatic close_header();
        if (size_acc == '0) begin
            expect_result(8'h00, 1'b0, 1'b0, ERR_ZERO_SIZE);
            chunk_seen = 1'b0;
            chunk_phase = HUNT_LF;
        end else begin
            chunk_left = size_acc;
            chunk_seen = 1'b1;
            chunk_phase = CHUNK_DATA;
        end
        size_acc = '0;
    endtask

    task automatic take_digit(input logic [7:0] b);
        logic [63:0] d;
        d = 64'(b - CH_ZERO);
        if (64'(size_acc) > (SIZE_MAX64 - d) / 64'd10) begin
            size_acc = '0;
            chunk_phase = HDR_OVERFLOW;
        end else begin
            size_acc = SIZE_BITS'(64'(size_acc) * 64'd10 + d);
            chunk_phase = HDR_DIGITS;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] seq [TAG_LEN+1];
        int         base, held, len, k, i, j;
        logic       ok, found, digit;
        base = deframed_q.size();
        digit = b inside {[CH_ZERO:CH_NINE]};
        if (framing_mode == 1'b0) begin
            held = (tag_held >= TAG_LEN) ? 0 : int'(tag_held);
            for (i = 0; i < held; i++) seq[i] = END_TAG[i];
            seq[held] = b;
            len = held + 1;
            k = (len < TAG_LEN) ? len : TAG_LEN;
            found = 1'b0;
            while (k > 0 && !found) begin
                ok = 1'b1;
                for (j = 0; j < k; j++) begin
                    if (seq[len - k + j] != END_TAG[j]) ok = 1'b0;
                end
                if (ok) found = 1'b1;
                else k--;
            end
            for (i = 0; i < len - k; i++) expect_result(seq[i], 1'b1, 1'b0, ERR_NONE);
            if (k == TAG_LEN) begin
                expect_result(8'h00, 1'b0, 1'b1, ERR_NONE);
                tag_held = 3'd0;
            end else begin
                tag_held = 3'(k);
            end
        end else begin
            case (chunk_phase)
                HUNT_LF: begin
                    if (b == CH_LF) chunk_phase = HUNT_HASH;
                end
                HUNT_HASH: begin
                    if (b == CH_HASH) begin
                        size_acc = '0;
                        chunk_phase = HDR_FIRST;
                    end else if (b != CH_LF) begin
                        chunk_phase = HUNT_LF;
                    end
                end
                HDR_FIRST: begin
                    if (b == CH_HASH) chunk_phase = HDR_END;
                    else if (b == CH_LF) close_header();
                    else if (digit) take_digit(b);
                    else chunk_phase = HDR_SKIP;
                end
                HDR_DIGITS: begin
                    if (b == CH_LF) close_header();
                    else if (digit) take_digit(b);
                    else chunk_phase = HDR_SKIP;
                end
                HDR_SKIP: begin
                    if (b == CH_LF) close_header();
                end
                HDR_END: begin
                    if (b == CH_LF) begin
                        if (chunk_seen) expect_result(8'h00, 1'b0, 1'b1, ERR_NONE);
                        else expect_result(8'h00, 1'b0, 1'b0, ERR_NO_CHUNK);
                        chunk_seen = 1'b0;
                        chunk_phase = HUNT_LF;
                    end else begin
                        size_acc = '0;
                        chunk_phase = HDR_SKIP;
                    end
                end
                CHUNK_DATA: begin
                    expect_result(b, 1'b1, 1'b0, ERR_NONE);
                    if (chunk_left != '0) chunk_left = chunk_left - SIZE_BITS'(1);
                    if (chunk_left == '0) chunk_phase = HUNT_LF;
                end
                default: begin
                    if (b == CH_LF) begin
                        expect_result(8'h00, 1'b0, 1'b0, ERR_OVERFLOW);
                        chunk_seen = 1'b0;
                        size_acc = '0;
                        chunk_phase = HUNT_LF;
                    end
                end
            endcase
        end
        if (deframed_q.size() > base) deframed_q[deframed_q.size() - 1].last = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input t_exp_kind kind);
        int        base;
        t_deframed want;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_in++;
        base = deframed_q.size();
        deframe_byte(b);
        if (kind != EXP_PREDICTED) begin
            while (deframed_q.size() > base) void'(deframed_q.pop_back());
            case (kind)
                EXP_SAME_BYTE: want = '{b, 1'b1, 1'b0, ERR_NONE, 1'b1};
                EXP_MSG_END:   want = '{8'h00, 1'b0, 1'b1, ERR_NONE, 1'b1};
                EXP_ZERO_SIZE: want = '{8'h00, 1'b0, 1'b0, ERR_ZERO_SIZE, 1'b1};
                default:       want = '{8'h00, 1'b0, 1'b0, ERR_NO_CHUNK, 1'b1};
            endcase
            deframed_q.push_back(want);
        end
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A write followed by a read of the mode register; psel stays high between them.
    task automatic program_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == MODE_ADDR) begin
            framing_mode = data[0];
            clear_framing();
        end
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= MODE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[0] !== framing_mode)
            flag_mismatch("framing_mode readback", prdata, 32'(framing_mode));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] tag_heavy_byte();
        case ($urandom_range(5))
            0: return CH_BRACKET;
            1: return CH_GT;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_endtag_burst();
        int cut;
        case ($urandom_range(9))
            0, 1: repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom_range(255)));
            2, 3: begin
                cut = $urandom_range(1, TAG_LEN - 1);
                for (int i = 0; i < cut; i++) tx_bytes.push_back(END_TAG[i]);
                tx_bytes.push_back(tag_heavy_byte());
            end
            default: begin
                repeat ($urandom_range(0, 8)) tx_bytes.push_back(tag_heavy_byte());
                for (int i = 0; i < TAG_LEN; i++) tx_bytes.push_back(END_TAG[i]);
            end
        endcase
    endtask

    task automatic queue_chunked_message();
        int    sz;
        string hdr;
        case ($urandom_range(11))
            0: repeat ($urandom_range(1, 5)) tx_bytes.push_back(8'($urandom_range(255)));
            1: push_text("\n##\n");
            2: begin
                case ($urandom_range(2))
                    0: push_text("\n#0\n");
                    1: push_text("\n#\n");
                    default: push_text("\n#q7\n");
                endcase
            end
            3: begin
                if ($urandom_range(1) == 0) push_text("\n#4294967296");
                else push_text($sformatf("\n#%0d%0d", $urandom_range(5, 9),
                                         $urandom_range(100000000, 999999999)));
                push_text("17x\n");
            end
            4: begin
                push_text("\n##");
                tx_bytes.push_back(8'($urandom_range(255)));
                push_text("\n");
            end
            default: begin
                repeat ($urandom_range(1, 3)) begin
                    sz = ($urandom_range(7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                    hdr = $sformatf("\n#%s%0d", ($urandom_range(5) == 0) ? "00" : "", sz);
                    push_text(hdr);
                    if ($urandom_range(5) == 0) push_text(" x");
                    push_text("\n");
                    repeat (sz) tx_bytes.push_back(8'($urandom_range(255)));
                end
                if ($urandom_range(9) != 0) push_text("\n##\n");
            end
        endcase
    endtask

    task automatic check_result();
        t_deframed want;
        if (deframed_q.size() == 0) begin
            flag_mismatch("result with nothing expected", 32'(o_data_byte), 32'd0);
            return;
        end
        want = deframed_q.pop_front();
        results_checked++;
        if (want.msg_end) ends_seen++;
        if (want.err != ERR_NONE) errors_seen++;
        if (o_data_byte !== want.data) flag_mismatch("data_byte", 32'(o_data_byte), 32'(want.data));
        if (o_data_valid !== want.valid)
            flag_mismatch("data_valid", 32'(o_data_valid), 32'(want.valid));
        if (o_message_end !== want.msg_end)
            flag_mismatch("message_end", 32'(o_message_end), 32'(want.msg_end));
        if (o_error_code !== want.err)
            flag_mismatch("error_code", 32'(o_error_code), 32'(want.err));
        if (o_last_result !== want.last)
            flag_mismatch("last_result", 32'(o_last_result), 32'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result();
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout with %0d results still expected", deframed_q.size());
            $display("netconf_message_deframer_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int sent;
        clear_framing();

        // End-tag mode: extremes, a delimiter broken by a bracket, then a full delimiter.
        dir_rows.push_back('{1'b0, 8'h00, EXP_SAME_BYTE});
        dir_rows.push_back('{1'b0, 8'hFF, EXP_SAME_BYTE});
        dir_rows.push_back('{1'b0, CH_BRACKET, EXP_PREDICTED});
        dir_rows.push_back('{1'b0, CH_BRACKET, EXP_PREDICTED});
        dir_rows.push_back('{1'b0, CH_GT, EXP_PREDICTED});
        dir_rows.push_back('{1'b0, CH_BRACKET, EXP_PREDICTED});
        dir_rows.push_back('{1'b0, CH_BRACKET, EXP_PREDICTED});
        dir_rows.push_back('{1'b0, CH_BRACKET, EXP_PREDICTED});
        dir_rows.push_back('{1'b0, CH_GT, EXP_PREDICTED});
        dir_rows.push_back('{1'b0, CH_BRACKET, EXP_PREDICTED});
        dir_rows.push_back('{1'b0, CH_BRACKET, EXP_PREDICTED});
        dir_rows.push_back('{1'b0, CH_GT, EXP_MSG_END});
        // Chunked mode: end with no chunk, a non-LF byte after the end marker,
        // a size cut short by a non-digit, then a proper end of message.
        dir_rows.push_back('{1'b1, CH_LF, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_HASH, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_HASH, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_LF, EXP_NO_CHUNK});
        dir_rows.push_back('{1'b1, CH_LF, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_HASH, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_HASH, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, 8'h78, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_LF, EXP_ZERO_SIZE});
        dir_rows.push_back('{1'b1, CH_LF, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_HASH, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, 8'h31, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, 8'h78, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_LF, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, 8'h41, EXP_SAME_BYTE});
        dir_rows.push_back('{1'b1, CH_LF, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_HASH, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_HASH, EXP_PREDICTED});
        dir_rows.push_back('{1'b1, CH_LF, EXP_MSG_END});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].mode != framing_mode) begin
                wait_quiet();
                program_reg(MODE_ADDR, {31'($urandom), dir_rows[r].mode});
            end
            send_byte(dir_rows[r].rx, dir_rows[r].kind);
        end

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            case (seg / 2)
                0: begin in_idle_pct = 9;  out_idle_pct = 48; end
                1: begin in_idle_pct = 48; out_idle_pct = 9;  end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            wait_quiet();
            if (seg == UNMAPPED_SEG) program_reg(UNMAPPED_ADDR, $urandom);
            else program_reg(MODE_ADDR, {31'($urandom), SEG_MODES[seg]});
            if (seg == PRESSURE_SEG) hold_arm <= 1'b1;
            sent = 0;
            tx_bytes.delete();
            while (sent < SEG_ITEMS || tx_bytes.size() != 0) begin
                if (tx_bytes.size() == 0) begin
                    if (framing_mode) queue_chunked_message();
                    else queue_endtag_burst();
                end
                send_byte(tx_bytes.pop_front(), EXP_PREDICTED);
                sent++;
            end
        end

        wait_quiet();
        $display("Run covered %0d bytes in both framing modes, under idling and a long stall.",
                 bytes_in);
        $display("Checked %0d results, among them %0d message ends and %0d framing errors.",
                 results_checked, ends_seen, errors_seen);
        if (mismatches == 0) begin
            $display("netconf_message_deframer_tb: PASS");
        end else begin
            $display("netconf_message_deframer_tb: FAIL");
        end
        $finish;
    end

endmodule
